### rtl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median core
// Heap geometry, result widths and the sequencer state type.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int Capacity   = 1024;
  localparam int HeapDepth  = (Capacity + 1) / 2;
  localparam int AddrW      = $clog2(HeapDepth);
  localparam int HcountW    = $clog2(HeapDepth + 1);
  localparam int CountW     = 11;
  localparam int ValueW     = 32;
  localparam int MedianW    = 33;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP_RD,     // read both tops
    ST_TOP_WT,     // top data valid, pick the path
    ST_DN_RDL,     // sift-down: read left child, or place at a leaf
    ST_DN_RDR,     // sift-down: read right child
    ST_DN_CMP,     // sift-down: compare, write hole
    ST_UP_RD,      // sift-up: read parent, or place at the root
    ST_UP_CMP,     // sift-up: compare, write hole
    ST_MED_RD,     // read final tops
    ST_MED_WT      // final tops valid, load the result
  } state_t;

endpackage

### rtl/running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core: running median over two heaps
// Command port: pulse start while busy is low with cmd and value. cmd clear
// empties both heaps; cmd insert adds value. One result per command is shown
// for one cycle with done: median_x2 (twice the median, 0 when empty), count
// (values held) and dropped (insert refused because the store was full).
// The receiver cannot stall; results are not held.
// The heaps live in two 512 x 32 single-port synchronous RAMs. An insert
// may sift the incoming value down the other heap (when it swaps through
// that heap's top) and then sifts a value up its own heap. Each level of
// sift-down reads the left child, reads the right child, then compares and
// writes the hole; each level of sift-up reads the parent, then compares
// and writes the hole. busy is high from the cycle after the transfer until
// done; the next transfer can be taken in the done cycle.
// Reset clears the counts and the sequencer; heap RAM contents need none,
// since only entries below the live counts are ever used.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core
  import rmth_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd,
  input  logic signed [ValueW-1:0]  value,
  output logic                      done,
  output logic signed [MedianW-1:0] median_x2,
  output logic [CountW-1:0]         count,
  output logic                      dropped
);

  function automatic logic ahead(input logic signed [ValueW-1:0] a,
                                 input logic signed [ValueW-1:0] b,
                                 input logic is_max);
    ahead = is_max ? (a > b) : (a < b);
  endfunction

  // heap RAMs: lower half in a max-heap, upper half in a min-heap
  logic signed [ValueW-1:0] lo_mem [HeapDepth];
  logic signed [ValueW-1:0] up_mem [HeapDepth];

  logic                     lo_we, up_we;
  logic [AddrW-1:0]         lo_addr, up_addr;
  logic signed [ValueW-1:0] lo_wd, up_wd;
  logic signed [ValueW-1:0] rd_lo, rd_up;

  always_ff @(posedge clk) begin
    if (lo_we) lo_mem[lo_addr] <= lo_wd;
    rd_lo <= lo_mem[lo_addr];
  end

  always_ff @(posedge clk) begin
    if (up_we) up_mem[up_addr] <= up_wd;
    rd_up <= up_mem[up_addr];
  end

  logic [HcountW-1:0] lo_cnt, up_cnt, lo_cnt_next, up_cnt_next;
  state_t state, state_next;

  // per-item registers
  logic                     op_clear;   // transfer was a clear
  logic                     op_drop;    // insert refused, store full
  logic                     to_up;      // upper heap is the one pushed
  logic signed [ValueW-1:0] dn_val;     // value sifted down the other heap
  logic signed [ValueW-1:0] push_val;   // value sifted up the target heap
  logic signed [ValueW-1:0] child_l;    // left child held for the compare
  logic [AddrW-1:0]         hole;       // current free slot

  // sift-down runs on the heap that is not pushed
  logic [HcountW-1:0]       dn_cnt, push_cnt;
  logic signed [ValueW-1:0] dn_rd, push_rd;
  assign dn_cnt   = to_up ? lo_cnt : up_cnt;
  assign push_cnt = to_up ? up_cnt : lo_cnt;
  assign dn_rd    = to_up ? rd_lo : rd_up;
  assign push_rd  = to_up ? rd_up : rd_lo;

  logic [HcountW:0] total;
  assign total = (HcountW+1)'(lo_cnt) + (HcountW+1)'(up_cnt);

  // swap through the other heap's top
  logic swap_in;
  assign swap_in = !op_clear && !op_drop && (dn_cnt != '0) &&
                   ahead(dn_rd, push_val, to_up);

  // child indices in a width that cannot overflow
  logic [AddrW+1:0] lchild, rchild;
  assign lchild = {1'b0, hole, 1'b1};
  assign rchild = lchild + (AddrW+2)'(1);

  // sift-down compare: left child held, right child on the read port
  logic                     l_ok, r_ok, c_right, dn_swap;
  logic signed [ValueW-1:0] c_val;
  assign l_ok    = lchild < (AddrW+2)'(dn_cnt);
  assign r_ok    = rchild < (AddrW+2)'(dn_cnt);
  assign c_right = r_ok && ahead(dn_rd, child_l, to_up);
  assign c_val   = c_right ? dn_rd : child_l;
  assign dn_swap = ahead(c_val, dn_val, to_up);

  // sift-up compare: parent on the read port
  logic [AddrW-1:0] parent;
  logic             push_swap;
  assign parent    = (hole - AddrW'(1)) >> 1;
  assign push_swap = ahead(push_val, push_rd, !to_up);

  // value reaches its final slot in the pushed heap
  logic placed;
  assign placed = ((state == ST_UP_RD) && (hole == '0)) ||
                  ((state == ST_UP_CMP) && !push_swap);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_TOP_RD;
      ST_TOP_RD: state_next = ST_TOP_WT;
      ST_TOP_WT: begin
        if (op_clear || op_drop) state_next = ST_MED_RD;
        else if (swap_in)        state_next = ST_DN_RDL;
        else                     state_next = ST_UP_RD;
      end
      ST_DN_RDL: state_next = l_ok ? ST_DN_RDR : ST_UP_RD;
      ST_DN_RDR: state_next = ST_DN_CMP;
      ST_DN_CMP: state_next = dn_swap ? ST_DN_RDL : ST_UP_RD;
      ST_UP_RD:  state_next = (hole == '0) ? ST_MED_RD : ST_UP_CMP;
      ST_UP_CMP: state_next = push_swap ? ST_UP_RD : ST_MED_RD;
      ST_MED_RD: state_next = ST_MED_WT;
      ST_MED_WT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM control, per role, then mapped onto the two heaps
  logic                     dn_we, push_we;
  logic [AddrW-1:0]         dn_addr, push_addr;
  logic signed [ValueW-1:0] dn_wd, push_wd;

  always_comb begin
    dn_we = 1'b0; dn_addr = '0; dn_wd = dn_val;
    push_we = 1'b0; push_addr = '0; push_wd = push_val;
    unique case (state)
      ST_DN_RDL: begin
        if (l_ok) begin
          dn_addr = lchild[AddrW-1:0];
        end else begin
          // hole is a leaf: the value settles here
          dn_we = 1'b1; dn_addr = hole;
        end
      end
      ST_DN_RDR: dn_addr = rchild[AddrW-1:0];
      ST_DN_CMP: begin
        dn_we = 1'b1; dn_addr = hole; dn_wd = dn_swap ? c_val : dn_val;
      end
      ST_UP_RD: begin
        if (hole == '0) push_we = 1'b1;
        else            push_addr = parent;
      end
      ST_UP_CMP: begin
        push_we = 1'b1; push_addr = hole; push_wd = push_swap ? push_rd : push_val;
      end
      default: ;
    endcase
  end

  assign lo_we   = to_up ? dn_we   : push_we;
  assign lo_addr = to_up ? dn_addr : push_addr;
  assign lo_wd   = to_up ? dn_wd   : push_wd;
  assign up_we   = to_up ? push_we   : dn_we;
  assign up_addr = to_up ? push_addr : dn_addr;
  assign up_wd   = to_up ? push_wd   : dn_wd;

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      lo_cnt <= '0;
      up_cnt <= '0;
    end else begin
      state  <= state_next;
      lo_cnt <= lo_cnt_next;
      up_cnt <= up_cnt_next;
    end
  end

  // counts
  always_comb begin
    lo_cnt_next = lo_cnt;
    up_cnt_next = up_cnt;
    if (state == ST_TOP_WT && op_clear) begin
      lo_cnt_next = '0;
      up_cnt_next = '0;
    end else if (placed) begin
      if (to_up) up_cnt_next = up_cnt + HcountW'(1);
      else       lo_cnt_next = lo_cnt + HcountW'(1);
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start) begin
        op_clear <= (cmd == CMD_CLEAR);
        op_drop  <= (cmd == CMD_INSERT) && (total >= (HcountW+1)'(Capacity));
        to_up    <= (total[0] == 1'b0);
        dn_val   <= value;
        push_val <= value;
      end
      ST_TOP_WT: begin
        if (swap_in) push_val <= dn_rd;
        hole <= swap_in ? '0 : AddrW'(push_cnt);
      end
      ST_DN_RDL: if (!l_ok) hole <= AddrW'(push_cnt);
      ST_DN_RDR: child_l <= dn_rd;
      ST_DN_CMP: begin
        if (dn_swap) hole <= c_right ? rchild[AddrW-1:0] : lchild[AddrW-1:0];
        else         hole <= AddrW'(push_cnt);
      end
      ST_UP_CMP: if (push_swap) hole <= parent;
      default: ;
    endcase
  end

  // median output
  logic signed [MedianW-1:0] lo_x, up_x;
  assign lo_x = {rd_lo[ValueW-1], rd_lo};
  assign up_x = {rd_up[ValueW-1], rd_up};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_MED_WT);
    end
    if (state == ST_MED_WT) begin
      count   <= CountW'(total);
      dropped <= op_drop;
      if (total == '0)     median_x2 <= '0;
      else if (total[0])   median_x2 <= up_x + up_x;
      else                 median_x2 <= lo_x + up_x;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

### rtl/rmth_checker.sv
// ----------------------------------------------------------------------------
// rmth_checker: port-level checks for the running median core
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module rmth_checker
  import rmth_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [MedianW-1:0] median_x2,
  input logic [CountW-1:0]         count,
  input logic                      dropped
);

  // a transfer makes the core busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after transfer");

  // done never stays high: each result is a single strobe
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

  // empty store reports zero median
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && count == '0) |-> (median_x2 == '0)) else $error("empty median");

  // count never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CountW'(Capacity))) else $error("count over capacity");

  // a refused insert only happens on a full store
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> (count == CountW'(Capacity))) else $error("drop not full");

endmodule

bind running_median_two_heaps_core rmth_checker u_rmth_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for running_median_two_heaps_core
// Drives insert and clear commands through the start/busy handshake.
// Keeps its own pair of heaps to compute the expected median, count and
// drop flag, then checks every done strobe field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import rmth_pkg::*;
();

  typedef struct {
    logic              op;
    logic [ValueW-1:0] val;
  } median_cmd_t;

  typedef struct {
    logic signed [MedianW-1:0] median;
    logic [CountW-1:0]         cnt;
    logic                      drop;
  } median_res_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      cmd;
  logic signed [ValueW-1:0]  value;
  logic                      done;
  logic signed [MedianW-1:0] median_x2;
  logic [CountW-1:0]         count;
  logic                      dropped;

  median_cmd_t pending_cmds[$];
  median_res_t expected_medians[$];

  // Shadow heaps: lo_heap is a max-heap, hi_heap a min-heap
  int lo_heap[HeapDepth];
  int hi_heap[HeapDepth];
  int lo_n;
  int hi_n;

  int  errors;
  int  n_sent;
  int  n_checked;
  int  n_drops;
  int  n_clears;
  int  max_held;
  int  idle_cnt;
  bit  quiet;
  bit  gen_done;
  bit  drained_once;

  running_median_two_heaps_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .value(value), .done(done), .median_x2(median_x2), .count(count),
    .dropped(dropped)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Heap helpers on the shadow model
  function automatic bit heap_ahead(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_push(ref int h[HeapDepth], input int n, input int v,
                           input bit is_max);
    int i;
    int p;
    int t;
    i = n;
    h[i] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!heap_ahead(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endtask

  task automatic heap_replace_top(ref int h[HeapDepth], input int n, input int v,
                                  input bit is_max);
    int i;
    int l;
    int c;
    int t;
    i = 0;
    h[0] = v;
    forever begin
      l = 2 * i + 1;
      if (l >= n) break;
      c = l;
      if (l + 1 < n && heap_ahead(h[l + 1], h[l], is_max)) c = l + 1;
      if (!heap_ahead(h[c], h[i], is_max)) break;
      t = h[i]; h[i] = h[c]; h[c] = t;
      i = c;
    end
  endtask

  // Expected result of one command, updating the shadow state
  task automatic predict_median(input median_cmd_t c);
    median_res_t r;
    int v;
    int top;
    int total;
    longint m;
    r.drop = 1'b0;
    if (c.op == CMD_CLEAR) begin
      lo_n = 0;
      hi_n = 0;
      n_clears++;
    end else if (lo_n + hi_n >= Capacity) begin
      r.drop = 1'b1;
      n_drops++;
    end else begin
      v = int'(signed'(c.val));
      if (((lo_n + hi_n) % 2) == 0) begin
        if (lo_n > 0 && v < lo_heap[0]) begin
          top = lo_heap[0];
          heap_replace_top(lo_heap, lo_n, v, 1'b1);
          v = top;
        end
        heap_push(hi_heap, hi_n, v, 1'b0);
        hi_n++;
      end else begin
        if (hi_n > 0 && v > hi_heap[0]) begin
          top = hi_heap[0];
          heap_replace_top(hi_heap, hi_n, v, 1'b0);
          v = top;
        end
        heap_push(lo_heap, lo_n, v, 1'b1);
        lo_n++;
      end
    end
    total = lo_n + hi_n;
    if (total > max_held) max_held = total;
    if (total == 0) m = 0;
    else if (total % 2) m = 2 * longint'(hi_heap[0]);
    else m = longint'(lo_heap[0]) + longint'(hi_heap[0]);
    r.median = m[MedianW-1:0];
    r.cnt = total[CountW-1:0];
    expected_medians.insert(expected_medians.size(), r);
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  function automatic median_cmd_t mk(logic op, logic [ValueW-1:0] v);
    median_cmd_t c;
    c.op = op;
    c.val = v;
    return c;
  endfunction

  // Append one command to the pending queue
  task automatic add_cmd(input logic op, input logic [ValueW-1:0] v);
    pending_cmds.insert(pending_cmds.size(), mk(op, v));
  endtask

  // Stimulus: directed corners, a fill past capacity, then random runs between clears
  initial begin
    int run_len;
    int k;
    add_cmd(CMD_INSERT, 32'h0000_0005);
    add_cmd(CMD_CLEAR, 32'hffff_ffff);
    add_cmd(CMD_INSERT, 32'h7fff_ffff);
    add_cmd(CMD_INSERT, 32'h7fff_ffff);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'h0000_0000);
    add_cmd(CMD_INSERT, 32'hffff_ffff);
    add_cmd(CMD_CLEAR, 32'h0);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_CLEAR, 32'h5555_aaaa);
    add_cmd(CMD_INSERT, 32'h7fff_ffff);
    add_cmd(CMD_INSERT, 32'h7fff_fffe);
    add_cmd(CMD_INSERT, 32'h7fff_ffff);
    add_cmd(CMD_CLEAR, 32'h0);
    // Fill to capacity and push past it to hit the full-store drop
    for (k = 0; k < Capacity + 3; k++)
      add_cmd(CMD_INSERT, rand_value());
    add_cmd(CMD_CLEAR, 32'h0);
    while (pending_cmds.size() < 1916) begin
      run_len = $urandom_range(1, 60);
      for (k = 0; k < run_len; k++)
        add_cmd($urandom_range(0, 49) == 0, rand_value());
      add_cmd(CMD_CLEAR, $urandom());
    end
    gen_done = 1'b1;
  end

  // Driver: one transfer per accepted start, random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= 1'b0;
      value <= '0;
      drained_once <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_median(mk(cmd, value));
        n_sent++;
      end
      if (start && busy) begin
        // Keep the current command until it is taken
      end else if (n_sent == 40 && !drained_once) begin
        // Pause once until every expected result has come back
        start <= 1'b0;
        if (expected_medians.size() == 0) drained_once <= 1'b1;
      end else if (pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
        median_cmd_t c;
        c = pending_cmds.pop_front();
        start <= 1'b1;
        cmd   <= c.op;
        value <= c.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // No idling for a stretch in the middle of the run
  always @(posedge clk) quiet <= (n_sent > 1100 && n_sent < 1500);

  // Monitor: compare each done strobe with the oldest expectation
  always @(posedge clk) begin
    median_res_t e;
    if (!rst && done) begin
      if (expected_medians.size() == 0) begin
        $error("result with nothing expected: median_x2=%0d", median_x2);
        errors++;
      end else begin
        e = expected_medians.pop_front();
        n_checked++;
        if (median_x2 !== e.median) begin
          $error("median_x2: expected %0d, got %0d", e.median, median_x2);
          errors++;
        end
        if (count !== e.cnt) begin
          $error("count: expected %0d, got %0d", e.cnt, count);
          errors++;
        end
        if (dropped !== e.drop) begin
          $error("dropped: expected %0d, got %0d", e.drop, dropped);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer or result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 2000) begin
      $display("Timeout: no transfer for %0d cycles", idle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    errors = 0; n_sent = 0; n_checked = 0; n_drops = 0; n_clears = 0;
    max_held = 0; lo_n = 0; hi_n = 0; quiet = 0;
    rst = 1'b1;
    start = 1'b0; cmd = 1'b0; value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (gen_done && pending_cmds.size() == 0);
    @(posedge clk);
    wait (!start && expected_medians.size() == 0);
    repeat (100) @(posedge clk);
    if (expected_medians.size() != 0) begin
      $error("%0d results never arrived", expected_medians.size());
      errors++;
    end
    $display("Ran %0d commands (%0d clears, %0d full-store drops), checked %0d results,",
             n_sent, n_clears, n_drops, n_checked);
    $display("store held up to %0d values", max_held);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rmth_pkg.sv
rtl/running_median_two_heaps_core.sv
rtl/rmth_checker.sv
tb/tb_top.sv
